### src/braille_utf8_pattern_store_top_macros.svh
// Assertion helpers for the braille pattern store.
`ifndef BRAILLE_UTF8_PATTERN_STORE_TOP_MACROS_SVH
`define BRAILLE_UTF8_PATTERN_STORE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BUPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bups assertion failed");
`define BUPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bups assertion failed");
`else
`define BUPS_ASSERT_NOW(label, clk, rst, ante, cons)
`define BUPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/bups_pkg.sv
`default_nettype none
package bups_pkg;

   localparam int CELL_COUNT_W = 7;
   localparam int CMD_IDX_W    = 9;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_END  = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [7:0] LEAD_BYTE    = 8'hE2;
   localparam logic [7:0] MID_MASK     = 8'hFC;
   localparam logic [7:0] MID_BASE     = 8'hA0;
   localparam logic [7:0] TAIL_MASK    = 8'hC0;
   localparam logic [7:0] TAIL_BASE    = 8'h80;
   localparam logic [7:0] DOT_LOW_MASK = 8'h3F;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] lead_byte;
      logic [7:0] mid_byte;
      logic [7:0] tail_byte;
      logic       has_cell;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_CLEAR,
      CMD_READ
   } cmd_op_type;

   // lo: store address or first cell to clear; hi: clear limit or read cell count
   typedef struct packed {
      cmd_op_type           op;
      logic [CMD_IDX_W-1:0] lo;
      logic [CMD_IDX_W-1:0] hi;
      logic [7:0]           dots;
   } cmd_type;

endpackage
`default_nettype wire

### src/braille_utf8_pattern_store_top.sv
// Channel  Dir  Handshake             Payload
// req      in   req_valid, req_stall  bups_pkg::req_type (action, payload_byte)
// rsp      out  rsp_valid, rsp_stall  bups_pkg::rsp_type (UTF-8 triplet, has_cell, last)
// csr      in   csr_wr_en             cell_count, 7 bits
//
// The front takes one transfer per cycle while the command queue has room.
// Back end: a store or an end-mark clear retires in IDLE; a read leaves IDLE, visits SCAN_RD
// and SCAN_CHK per cell checked walking back (the blanks and the last filled cell), then
// EMIT_RD (registered RAM read) and EMIT_LOAD per triplet sent; an empty reply uses EMPTY.
// Reset is synchronous; it clears the per-cell valid bits at once, no clearing pass.
// req_stall rises while the queue is full; rsp_stall holds the output register and emit walk.
`default_nettype none
module braille_utf8_pattern_store_top #(
   parameter int MAX_CELLS   = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bups_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bups_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [bups_pkg::CELL_COUNT_W-1:0] csr_wr_data
);
   logic [bups_pkg::CELL_COUNT_W-1:0] cell_count_ff;
   logic                              q_full;
   logic                              q_empty;
   logic                              q_push;
   logic                              q_pop;
   bups_pkg::cmd_type                 push_cmd;
   bups_pkg::cmd_type                 pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= '0;
      end else if (csr_wr_en) begin
         cell_count_ff <= csr_wr_data;
      end
   end

   bups_front #(
      .MAX_CELLS(MAX_CELLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cell_count(cell_count_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   bups_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (pop_cmd),
      .empty    (q_empty)
   );

   bups_back #(
      .MAX_CELLS(MAX_CELLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_cmd    (pop_cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

### src/bups_ram.sv
`default_nettype none
module bups_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/bups_front.sv
`default_nettype none
`include "braille_utf8_pattern_store_top_macros.svh"
module bups_front #(
   parameter int MAX_CELLS = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire bups_pkg::req_type                      req_data,
   input  wire logic [bups_pkg::CELL_COUNT_W-1:0]      cell_count,
   input  wire logic                                   q_full,
   output logic                                        q_push,
   output bups_pkg::cmd_type                           q_cmd
);
   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam int IW = bups_pkg::CMD_IDX_W;

   localparam logic [1:0] POS_LEAD = 2'd0;
   localparam logic [1:0] POS_MID  = 2'd1;
   localparam logic [1:0] POS_TAIL = 2'd2;

   logic [CW-1:0] n_cells;
   logic          accept;
   logic [7:0]    b;

   logic [CW-1:0] wp_ff,      wp_in;
   logic [1:0]    tp_ff,      tp_in;
   logic [7:0]    held_ff,    held_in;
   logic          lead_ok_ff, lead_ok_in;
   logic          stopped_ff, stopped_in;

   assign n_cells = (32'(cell_count) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(cell_count);
   assign req_stall = q_full;
   assign accept = req_valid && !q_full;
   assign b = req_data.payload_byte;

   always_comb begin
      wp_in      = wp_ff;
      tp_in      = tp_ff;
      held_in    = held_ff;
      lead_ok_in = lead_ok_ff;
      stopped_in = stopped_ff;
      q_push     = 1'b0;
      q_cmd      = '0;
      if (accept) begin
         unique case (req_data.action)
            bups_pkg::ACT_BYTE: begin
               if (!stopped_ff) begin
                  if (wp_ff >= n_cells) begin
                     stopped_in = 1'b1;
                  end else begin
                     priority if (tp_ff == POS_LEAD) begin
                        lead_ok_in = (b == bups_pkg::LEAD_BYTE);
                        if (b != bups_pkg::LEAD_BYTE) begin
                           stopped_in = 1'b1;
                        end else begin
                           tp_in = POS_MID;
                        end
                     end else if (tp_ff == POS_MID) begin
                        if ((b & bups_pkg::MID_MASK) != bups_pkg::MID_BASE) begin
                           stopped_in = 1'b1;
                        end else begin
                           held_in = b;
                           tp_in   = POS_TAIL;
                        end
                     end else begin
                        if (!lead_ok_ff || (b & bups_pkg::TAIL_MASK) != bups_pkg::TAIL_BASE) begin
                           stopped_in = 1'b1;
                        end else begin
                           q_push     = 1'b1;
                           q_cmd.op   = bups_pkg::CMD_STORE;
                           q_cmd.lo   = IW'(wp_ff);
                           q_cmd.dots = {held_ff[1:0], b[5:0]};
                           wp_in      = wp_ff + CW'(1);
                           tp_in      = POS_LEAD;
                           lead_ok_in = 1'b0;
                           // stop once the display is full
                           if (wp_ff + CW'(1) >= n_cells) begin
                              stopped_in = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
            bups_pkg::ACT_END: begin
               q_push     = 1'b1;
               q_cmd.op   = bups_pkg::CMD_CLEAR;
               q_cmd.lo   = IW'(wp_ff);
               q_cmd.hi   = IW'(n_cells);
               wp_in      = '0;
               tp_in      = POS_LEAD;
               held_in    = '0;
               lead_ok_in = 1'b0;
               stopped_in = 1'b0;
            end
            bups_pkg::ACT_READ: begin
               q_push   = 1'b1;
               q_cmd.op = bups_pkg::CMD_READ;
               q_cmd.hi = IW'(n_cells);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         tp_ff      <= POS_LEAD;
         held_ff    <= '0;
         lead_ok_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         tp_ff      <= tp_in;
         held_ff    <= held_in;
         lead_ok_ff <= lead_ok_in;
         stopped_ff <= stopped_in;
      end
   end

   `BUPS_ASSERT_NOW(a_tail_needs_lead, clock, reset, tp_ff == POS_TAIL, lead_ok_ff)
endmodule
`default_nettype wire

### src/bups_queue.sv
`default_nettype none
`include "braille_utf8_pattern_store_top_macros.svh"
module bups_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bups_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output bups_pkg::cmd_type      pop_data,
   output logic                   empty
);
   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bups_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BUPS_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `BUPS_ASSERT_NOW(a_no_push_full, clock, reset, push, !full)
   `BUPS_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !empty)
endmodule
`default_nettype wire

### src/bups_back.sv
`default_nettype none
`include "braille_utf8_pattern_store_top_macros.svh"
module bups_back #(
   parameter int MAX_CELLS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   output logic                   q_pop,
   input  wire bups_pkg::cmd_type q_cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bups_pkg::rsp_type      rsp_data
);
   localparam int AW = MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1;
   localparam int IW = bups_pkg::CMD_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMPTY
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      last_idx_ff, last_idx_in;
   logic [MAX_CELLS-1:0] valid_ff, valid_in;
   logic               rd_valid_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bups_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [7:0]         rd_data;
   logic [7:0]         rd_dots;
   logic               out_free;

   bups_ram #(
      .WIDTH(8),
      .DEPTH(MAX_CELLS)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(q_cmd.dots),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   // cells never written since reset or since the last clear read as blank
   assign rd_dots  = rd_valid_ff ? rd_data : 8'h00;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_addr  = AW'(q_cmd.lo);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  bups_pkg::CMD_STORE: begin
                     wr_en             = 1'b1;
                     valid_in[wr_addr] = 1'b1;
                  end
                  bups_pkg::CMD_CLEAR: begin
                     for (int i = 0; i < MAX_CELLS; i++) begin
                        if (IW'(i) >= q_cmd.lo && IW'(i) < q_cmd.hi) begin
                           valid_in[i] = 1'b0;
                        end
                     end
                  end
                  bups_pkg::CMD_READ: begin
                     if (q_cmd.hi == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        idx_in   = AW'(q_cmd.hi - IW'(1));
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            // walk back past trailing blank cells
            priority if (rd_dots != 8'h00) begin
               last_idx_in = idx_ff;
               idx_in      = '0;
               state_in    = ST_EMIT_RD;
            end else if (idx_ff == '0) begin
               state_in = ST_EMPTY;
            end else begin
               idx_in   = idx_ff - AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.lead_byte = bups_pkg::LEAD_BYTE;
               rsp_data_in.mid_byte  = bups_pkg::MID_BASE | {6'b000000, rd_dots[7:6]};
               rsp_data_in.tail_byte = bups_pkg::TAIL_BASE | (rd_dots & bups_pkg::DOT_LOW_MASK);
               rsp_data_in.has_cell  = 1'b1;
               rsp_data_in.last      = (idx_ff == last_idx_ff);
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.lead_byte = 8'h00;
               rsp_data_in.mid_byte  = 8'h00;
               rsp_data_in.tail_byte = 8'h00;
               rsp_data_in.has_cell  = 1'b0;
               rsp_data_in.last      = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      rd_valid_ff <= valid_ff[idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BUPS_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid_ff && !rsp_data_ff.has_cell, rsp_data_ff.last && rsp_data_ff.lead_byte == 8'h00)
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int DISPLAY_MAX    = 64;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 20;
   localparam int NUM_PHASES     = 9;
   localparam int PRESSURE_PHASE = 7;
   localparam int PHASE_ITEMS    = 8;
   localparam int FILL_CELLS     = 16;
   localparam int FILL_READS     = 5;

   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam bups_pkg::rsp_type EMPTY_REPLY = '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
   localparam bups_pkg::rsp_type ALL_DOTS    = '{bups_pkg::LEAD_BYTE, 8'hA3, 8'hBF, 1'b1, 1'b1};

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {AT_LEAD, AT_MID, AT_TAIL} triplet_slot_type;

   typedef struct {
      row_kind_type      kind;
      bups_pkg::req_type item;
      bit                fixed;
      bups_pkg::rsp_type want;
      logic [6:0]        cells;
   } plan_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   bups_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   bups_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [6:0]        csr_wr_data = '0;

   // predicted display state
   logic [7:0]       dots_mem [0:DISPLAY_MAX-1];
   logic [6:0]       disp_cells = '0;
   int unsigned      fill_ptr   = 0;
   triplet_slot_type byte_slot  = AT_LEAD;
   logic [7:0]       mid_keep   = '0;
   bit               lead_good  = 1'b0;
   bit               decode_off = 1'b0;

   bups_pkg::rsp_type cell_replies_due [$];
   plan_row_type      directed_rows [$];
   bups_pkg::req_type phase_plan [$];

   int unsigned send_pct      = 0;
   int unsigned stall_pct     = 0;
   bit          hold_on       = 1'b0;
   int unsigned holds_done    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned mismatches    = 0;
   int unsigned reqs_sent     = 0;
   int unsigned reads_sent    = 0;
   int unsigned cells_checked = 0;
   int unsigned cfg_writes    = 0;
   int unsigned stall_cycles  = 0;

   braille_utf8_pattern_store_top #(
      .MAX_CELLS(DISPLAY_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned cells_in_use();
      return (disp_cells > DISPLAY_MAX) ? DISPLAY_MAX : int'(disp_cells);
   endfunction

   function automatic bups_pkg::req_type mk_req(input logic [1:0] act, input logic [7:0] b);
      bups_pkg::req_type r;
      r.action       = act;
      r.payload_byte = b;
      return r;
   endfunction

   function automatic plan_row_type item_row(input logic [1:0] act, input logic [7:0] b);
      plan_row_type r;
      r.kind  = ROW_ITEM;
      r.item  = mk_req(act, b);
      r.fixed = 1'b0;
      r.want  = EMPTY_REPLY;
      r.cells = '0;
      return r;
   endfunction

   function automatic plan_row_type fixed_row(input logic [1:0] act,
                                              input bups_pkg::rsp_type want);
      plan_row_type r;
      r       = item_row(act, 8'h00);
      r.fixed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic plan_row_type cfg_row(input logic [6:0] cells);
      plan_row_type r;
      r       = item_row(ACT_SPARE, 8'h00);
      r.kind  = ROW_CFG;
      r.cells = cells;
      return r;
   endfunction

   task automatic add_triplet_rows(input logic [7:0] mid, input logic [7:0] tail);
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, bups_pkg::LEAD_BYTE));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, mid));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, tail));
   endtask

   task automatic predict_payload(input logic [7:0] b);
      if (decode_off) begin
      end else if (fill_ptr >= cells_in_use()) begin
         decode_off = 1'b1;
      end else begin
         case (byte_slot)
            AT_LEAD: begin
               lead_good = (b == bups_pkg::LEAD_BYTE);
               if (!lead_good) decode_off = 1'b1;
               else byte_slot = AT_MID;
            end
            AT_MID: begin
               if ((b & bups_pkg::MID_MASK) != bups_pkg::MID_BASE) begin
                  decode_off = 1'b1;
               end else begin
                  mid_keep  = b;
                  byte_slot = AT_TAIL;
               end
            end
            default: begin
               if (!lead_good || (b & bups_pkg::TAIL_MASK) != bups_pkg::TAIL_BASE) begin
                  decode_off = 1'b1;
               end else begin
                  dots_mem[fill_ptr] = {mid_keep[1:0], b[5:0]};
                  fill_ptr++;
                  byte_slot = AT_LEAD;
                  lead_good = 1'b0;
                  if (fill_ptr >= cells_in_use()) decode_off = 1'b1;
               end
            end
         endcase
      end
   endtask

   task automatic predict_end_mark();
      int unsigned i;
      for (i = fill_ptr; i < cells_in_use(); i++) dots_mem[i] = 8'h00;
      fill_ptr   = 0;
      byte_slot  = AT_LEAD;
      mid_keep   = 8'h00;
      lead_good  = 1'b0;
      decode_off = 1'b0;
   endtask

   task automatic predict_read_reply();
      int unsigned span;
      int unsigned i;
      bups_pkg::rsp_type r;
      span = cells_in_use();
      // drop trailing blank cells
      while (span > 0 && dots_mem[span-1] == 8'h00) span--;
      if (span == 0) begin
         cell_replies_due.push_back(EMPTY_REPLY);
      end else begin
         for (i = 0; i < span; i++) begin
            r.lead_byte = bups_pkg::LEAD_BYTE;
            r.mid_byte  = bups_pkg::MID_BASE | {6'b0, dots_mem[i][7:6]};
            r.tail_byte = bups_pkg::TAIL_BASE | (dots_mem[i] & bups_pkg::DOT_LOW_MASK);
            r.has_cell  = 1'b1;
            r.last      = (i + 1 == span);
            cell_replies_due.push_back(r);
         end
      end
   endtask

   task automatic predict_transfer(input bups_pkg::req_type it);
      case (it.action)
         bups_pkg::ACT_BYTE: predict_payload(it.payload_byte);
         bups_pkg::ACT_END:  predict_end_mark();
         bups_pkg::ACT_READ: predict_read_reply();
         default: begin
         end
      endcase
   endtask

   // offer one item, hold it through stalls, then maybe idle
   task automatic push_req(input bups_pkg::req_type it, input bit fixed,
                           input bups_pkg::rsp_type want);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) begin
         stall_cycles++;
         @(posedge clock);
      end
      if (it.action == bups_pkg::ACT_READ) reads_sent++;
      if (fixed) cell_replies_due.push_back(want);
      else predict_transfer(it);
      reqs_sent++;
      if ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_pct) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (cell_replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_cell_count(input logic [6:0] cells);
      req_valid <= 1'b0;
      wait_drained();
      // let end marks and payload bytes still queued in the block retire
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cells;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      disp_cells  = cells;
      cfg_writes++;
   endtask

   task automatic add_packet(input int unsigned n, input bit solid, input bit messy);
      logic [7:0] pkt [$];
      logic [7:0] c;
      int unsigned i;
      int unsigned cut;
      for (i = 0; i < n; i++) begin
         if (solid) c = 8'($urandom_range(255, 1));
         else if ($urandom_range(3) == 0) c = 8'h00;
         else c = 8'($urandom_range(255));
         pkt.push_back(bups_pkg::LEAD_BYTE);
         pkt.push_back(bups_pkg::MID_BASE | {6'b0, c[7:6]});
         pkt.push_back(bups_pkg::TAIL_BASE | (c & bups_pkg::DOT_LOW_MASK));
      end
      if (messy && pkt.size() != 0) begin
         if ($urandom_range(99) < 15) pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom_range(255));
         if ($urandom_range(99) < 15) begin
            cut = $urandom_range(2, 1);
            while (cut != 0 && pkt.size() != 0) begin
               void'(pkt.pop_back());
               cut--;
            end
         end
      end
      for (i = 0; i < pkt.size(); i++) begin
         if (messy && $urandom_range(99) < 3)
            phase_plan.push_back(mk_req(bups_pkg::ACT_READ, 8'($urandom_range(255))));
         phase_plan.push_back(mk_req(bups_pkg::ACT_BYTE, pkt[i]));
      end
      phase_plan.push_back(mk_req(bups_pkg::ACT_END, 8'($urandom_range(255))));
   endtask

   task automatic build_phase_plan(input int unsigned lead_cells, input int unsigned count);
      int unsigned pick;
      int unsigned goal;
      int unsigned span;
      phase_plan.delete();
      if (lead_cells != 0) begin
         add_packet(lead_cells, 1'b1, 1'b0);
         // several reads in a row pile up behind a stalled reply
         repeat (FILL_READS)
            phase_plan.push_back(mk_req(bups_pkg::ACT_READ, 8'($urandom_range(255))));
      end
      goal = phase_plan.size() + count;
      while (phase_plan.size() < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            span = (cells_in_use() < 6) ? cells_in_use() + 1 : 6;
            add_packet($urandom_range(span), 1'b0, 1'b1);
            if ($urandom_range(99) < 70)
               phase_plan.push_back(mk_req(bups_pkg::ACT_READ, 8'($urandom_range(255))));
         end else if (pick < 72) begin
            phase_plan.push_back(mk_req(bups_pkg::ACT_READ, 8'($urandom_range(255))));
         end else if (pick < 84) begin
            phase_plan.push_back(mk_req(bups_pkg::ACT_BYTE, 8'($urandom_range(255))));
         end else if (pick < 92) begin
            phase_plan.push_back(mk_req(ACT_SPARE, 8'($urandom_range(255))));
         end else begin
            phase_plan.push_back(mk_req(bups_pkg::ACT_END, 8'($urandom_range(255))));
         end
      end
   endtask

   task automatic check_cell_reply(input bups_pkg::rsp_type got);
      bups_pkg::rsp_type want;
      if (cell_replies_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, actual lead=%h mid=%h tail=%h has_cell=%b last=%b",
                     $time, got.lead_byte, got.mid_byte, got.tail_byte, got.has_cell, got.last);
      end else begin
         want = cell_replies_due.pop_front();
         cells_checked++;
         if (got.lead_byte !== want.lead_byte || got.mid_byte !== want.mid_byte ||
             got.tail_byte !== want.tail_byte || got.has_cell !== want.has_cell ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: mismatch, expected %h %h %h has_cell=%b last=%b, actual %h %h %h has_cell=%b last=%b",
                        $time, want.lead_byte, want.mid_byte, want.tail_byte, want.has_cell,
                        want.last, got.lead_byte, got.mid_byte, got.tail_byte, got.has_cell,
                        got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_cell_reply(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, cell_replies_due.size());
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_drive
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_on) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_on = 1'b0;
            holds_done++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : stimulus
      int unsigned r;
      int unsigned ph;
      logic [6:0] cells;
      foreach (dots_mem[i]) dots_mem[i] = 8'h00;

      // count zero right after reset: nothing decodes, reads come back empty
      directed_rows.push_back(fixed_row(bups_pkg::ACT_READ, EMPTY_REPLY));
      add_triplet_rows(8'hA3, 8'hBF);
      directed_rows.push_back(item_row(bups_pkg::ACT_END, 8'h00));
      directed_rows.push_back(fixed_row(bups_pkg::ACT_READ, EMPTY_REPLY));
      // all dots, then a blank cell that fills the display
      directed_rows.push_back(cfg_row(7'd2));
      add_triplet_rows(8'hA3, 8'hBF);
      add_triplet_rows(bups_pkg::MID_BASE, bups_pkg::TAIL_BASE);
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, bups_pkg::LEAD_BYTE));
      directed_rows.push_back(fixed_row(bups_pkg::ACT_READ, ALL_DOTS));
      directed_rows.push_back(item_row(bups_pkg::ACT_END, 8'hFF));
      // count above the display size saturates; bad mid byte stops decoding
      directed_rows.push_back(cfg_row(7'd127));
      add_triplet_rows(8'hA1, 8'h8C);
      directed_rows.push_back(item_row(bups_pkg::ACT_READ, 8'hFF));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, bups_pkg::LEAD_BYTE));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, 8'hA4));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, 8'h00));
      directed_rows.push_back(item_row(bups_pkg::ACT_END, 8'h00));
      directed_rows.push_back(item_row(bups_pkg::ACT_READ, 8'h00));
      // incomplete triplet is dropped and the whole store clears
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, bups_pkg::LEAD_BYTE));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, 8'hA2));
      directed_rows.push_back(item_row(bups_pkg::ACT_END, 8'h00));
      directed_rows.push_back(fixed_row(bups_pkg::ACT_READ, EMPTY_REPLY));
      directed_rows.push_back(item_row(ACT_SPARE, 8'hFF));
      directed_rows.push_back(item_row(bups_pkg::ACT_BYTE, 8'h00));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < directed_rows.size(); r++) begin
         if (directed_rows[r].kind == ROW_CFG) write_cell_count(directed_rows[r].cells);
         else push_req(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].want);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: cells = 7'd64;
            1: cells = 7'd1;
            2: cells = 7'd5;
            3: cells = 7'd127;
            4: cells = 7'd0;
            5: cells = 7'd3;
            6: cells = 7'd65;
            7: cells = 7'd8;
            default: cells = 7'($urandom_range(127));
         endcase
         write_cell_count(cells);
         send_pct  = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 33 : 0;
         stall_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 33 : 0;
         if (ph == 0) build_phase_plan(FILL_CELLS, PHASE_ITEMS);
         else if (ph == PRESSURE_PHASE) build_phase_plan(6, PHASE_ITEMS);
         else build_phase_plan(0, PHASE_ITEMS);
         if (ph == PRESSURE_PHASE) begin
            // keep offering while the result side holds off
            send_pct = 0;
            hold_on  = 1'b1;
         end
         for (r = 0; r < phase_plan.size(); r++) push_req(phase_plan[r], 1'b0, EMPTY_REPLY);
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request transfers (%0d reads), %0d result transfers, %0d cell count writes",
               reqs_sent, reads_sent, cells_checked, cfg_writes);
      $display("input stalled for %0d cycles, %0d long hold-offs, %0d mismatches",
               stall_cycles, holds_done, mismatches);
      if (mismatches == 0 && cell_replies_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
